FILE: design/u2da_pkg.sv
// shared constants and types for the 32-bit binary to decimal ascii converter
// no dependencies; imported by u2da_cell and uint32_to_decimal_ascii_core
package u2da_pkg;

    localparam int VALUE_W    = 32;
    localparam int SIZE_W     = 8;
    localparam int CHAR_W     = 6;
    localparam int BCD_W      = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] ASCII_NUL  = CHAR_W'(0);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    // control shared by every cell of the chain
    typedef struct packed {
        logic clear;
        logic dabble;
        logic move;
    } t_cell_ctl;

endpackage

FILE: design/u2da_cell.sv
// one bcd digit cell of the double-dabble chain
// depends on u2da_pkg for widths and the cell control struct
module u2da_cell (
    input  logic                      i_clk,
    input  u2da_pkg::t_cell_ctl       i_ctl,
    input  logic                      i_carry,
    input  logic [u2da_pkg::BCD_W-1:0] i_digit,
    output logic                      o_carry,
    output logic [u2da_pkg::BCD_W-1:0] o_digit
);
    import u2da_pkg::*;

    logic [BCD_W-1:0] r_digit;
    logic [BCD_W-1:0] n_digit;
    logic [BCD_W-1:0] w_adj;

    // add three before the shift so the digit wraps at ten
    assign w_adj   = (r_digit >= BCD_W'(5)) ? r_digit + BCD_W'(3) : r_digit;
    assign o_carry = w_adj[BCD_W-1];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.dabble) begin
            n_digit = {w_adj[BCD_W-2:0], i_carry};
        end else if (i_ctl.move) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

FILE: design/uint32_to_decimal_ascii_core.sv
// top level: converts a 32-bit unsigned value to decimal ascii characters
// depends on u2da_pkg and a chain of u2da_cell digit cells
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+---------------------------
//  input   | i_valid | o_ready | i_value, i_buffer_size
//  output  | o_valid | i_ready | o_character, o_last
//
// an item runs through double-dabble in the ten digit cells (one value bit
// per cycle), then skips each leading zero and sends each character in turn.
// a buffer size below two is taken and gives no characters.
// reset (synchronous, active low) returns the sequencer to idle and empties
// the output register. output stalls hold the sequencer in the emit phase.
module uint32_to_decimal_ascii_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [u2da_pkg::VALUE_W-1:0]  i_value,
    input  logic [u2da_pkg::SIZE_W-1:0]   i_buffer_size,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [u2da_pkg::CHAR_W-1:0]   o_character,
    output logic                          o_last
);
    import u2da_pkg::*;

    t_state                 r_state, n_state;
    logic [VALUE_W-1:0]     r_value, n_value;
    logic [BIT_CNT_W-1:0]   r_bit, n_bit;
    logic [DIGIT_CNT_W-1:0] r_left, n_left;
    logic [DIGIT_CNT_W-1:0] r_limit, n_limit;
    logic                   r_started, n_started;
    logic                   r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]      r_char, n_char;
    logic                   r_last, n_last;

    t_cell_ctl              w_ctl;
    logic [NUM_DIGITS:0]    w_carry;
    logic [BCD_W-1:0]       w_digit [NUM_DIGITS];
    logic [BCD_W-1:0]       w_top;
    logic                   w_slot_free;
    logic                   w_in_txn;

    // cell 0 is least significant; digits move up towards the top cell
    assign w_carry[0] = r_value[VALUE_W-1];

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++) begin : g_cell
            u2da_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_carry (w_carry[g]),
                .i_digit ((g == 0) ? BCD_W'(0) : w_digit[(g == 0) ? 0 : g-1]),
                .o_carry (w_carry[g+1]),
                .o_digit (w_digit[g])
            );
        end
    endgenerate

    assign w_top       = w_digit[NUM_DIGITS-1];
    assign o_ready     = (r_state == ST_IDLE);
    assign w_in_txn    = i_valid && o_ready;
    assign w_slot_free = !r_out_valid || i_ready;
    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_bit       = r_bit;
        n_left      = r_left;
        n_limit     = r_limit;
        n_started   = r_started;
        n_out_valid = r_out_valid && !i_ready;
        n_char      = r_char;
        n_last      = r_last;
        w_ctl       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_txn && (i_buffer_size >= SIZE_W'(2))) begin
                    w_ctl.clear = 1'b1;
                    n_value     = i_value;
                    n_bit       = '0;
                    n_left      = DIGIT_CNT_W'(NUM_DIGITS);
                    n_started   = 1'b0;
                    n_limit     = (i_buffer_size > SIZE_W'(NUM_DIGITS))
                                ? DIGIT_CNT_W'(NUM_DIGITS)
                                : DIGIT_CNT_W'(i_buffer_size - SIZE_W'(1));
                    n_state     = ST_CONV;
                end
            end
            ST_CONV: begin
                w_ctl.dabble = 1'b1;
                n_value      = {r_value[VALUE_W-2:0], 1'b0};
                n_bit        = r_bit + BIT_CNT_W'(1);
                if (r_bit == BIT_CNT_W'(VALUE_W - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_started && (w_top == '0) && (r_left > DIGIT_CNT_W'(1))) begin
                    // drop a leading zero, a lone zero digit is still sent
                    w_ctl.move = 1'b1;
                    n_left     = r_left - DIGIT_CNT_W'(1);
                end else if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    if ((r_limit != '0) && (r_left != '0)) begin
                        w_ctl.move = 1'b1;
                        n_left     = r_left - DIGIT_CNT_W'(1);
                        n_limit    = r_limit - DIGIT_CNT_W'(1);
                        n_started  = 1'b1;
                        n_char     = ASCII_ZERO + CHAR_W'(w_top);
                        n_last     = 1'b0;
                    end else begin
                        n_char  = ASCII_NUL;
                        n_last  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_bit     <= n_bit;
        r_left    <= n_left;
        r_limit   <= n_limit;
        r_started <= n_started;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    // a 32-bit value never overflows ten decimal digits
    a_no_top_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> !w_carry[NUM_DIGITS])
        else $error("carry out of the most significant digit cell");

    a_digit_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |->
            (o_character >= ASCII_ZERO) && (o_character <= ASCII_ZERO + CHAR_W'(9)))
        else $error("non-final character is not a decimal digit");

    a_nul_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_character == ASCII_NUL))
        else $error("final character is not nul");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |->
            (r_left <= DIGIT_CNT_W'(NUM_DIGITS)) && (r_limit <= DIGIT_CNT_W'(NUM_DIGITS)))
        else $error("digit counters out of range");

    a_emit_after_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_CONV) && (r_bit == BIT_CNT_W'(VALUE_W - 1))) |=>
            (r_state == ST_EMIT))
        else $error("conversion did not hand over to emission");

endmodule

FILE: sim/uint32_to_decimal_ascii_core_checker.sv
// checker for the binary to decimal ascii converter: predicts the character
// stream of every input transaction and compares each output transaction
// depends on u2da_pkg for widths and character codes
`timescale 1ns / 100ps

module uint32_to_decimal_ascii_core_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [u2da_pkg::VALUE_W-1:0]  i_value,
    input  logic [u2da_pkg::SIZE_W-1:0]   i_buffer_size,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [u2da_pkg::CHAR_W-1:0]   i_character,
    input  logic                          i_last,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_value_count,
    output int                            o_silent_count,
    output int                            o_char_count
);

    import u2da_pkg::*;

    localparam int DECIMAL_BASE = 10;
    localparam int MIN_SIZE     = 2;
    localparam int MAX_REPORTS  = 20;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_beat;

    t_char_beat expected_chars[$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_value_count  = 0;
        o_silent_count = 0;
        o_char_count   = 0;
    end

    task automatic report_mismatch(input string what);
        if (o_fail_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
        o_fail_count = o_fail_count + 1;
    endtask

    // digits most significant first, cut to size-1, then the terminating nul
    function automatic void queue_decimal_string(input logic [VALUE_W-1:0] value,
                                                 input logic [SIZE_W-1:0] size);
        logic [BCD_W-1:0] digs [NUM_DIGITS];
        logic [VALUE_W-1:0] rest;
        int n;
        int keep;
        t_char_beat beat;
        if (int'(size) < MIN_SIZE) begin
            o_silent_count = o_silent_count + 1;
            return;
        end
        rest = value;
        n    = 0;
        do begin
            digs[n] = BCD_W'(rest % DECIMAL_BASE);
            rest    = rest / DECIMAL_BASE;
            n++;
        end while (rest != 0);
        keep = (int'(size) - 1 < n) ? int'(size) - 1 : n;
        for (int k = 0; k < keep; k++) begin
            beat.ch   = ASCII_ZERO + CHAR_W'(digs[n - 1 - k]);
            beat.last = 1'b0;
            expected_chars.push_back(beat);
        end
        beat.ch   = ASCII_NUL;
        beat.last = 1'b1;
        expected_chars.push_back(beat);
    endfunction

    always @(posedge i_clk) begin
        t_char_beat want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                o_char_count = o_char_count + 1;
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected character %0d last %0b",
                                              i_character, i_last));
                end else begin
                    want = expected_chars.pop_front();
                    if (i_character !== want.ch)
                        report_mismatch($sformatf("character %0d, wanted %0d",
                                                  i_character, want.ch));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("last %0b, wanted %0b on character %0d",
                                                  i_last, want.last, want.ch));
                end
            end
            if (i_in_valid && i_in_ready) begin
                o_value_count = o_value_count + 1;
                queue_decimal_string(i_value, i_buffer_size);
            end
        end
        o_pending <= expected_chars.size();
    end

endmodule

FILE: sim/uint32_to_decimal_ascii_core_tb.sv
// testbench top for uint32_to_decimal_ascii_core: clock, reset, stimulus,
// output back-pressure, watchdog and verdict
// depends on u2da_pkg, the core and uint32_to_decimal_ascii_core_checker
`timescale 1ns / 100ps

module uint32_to_decimal_ascii_core_tb;

    import u2da_pkg::*;

    localparam int  CLK_HALF      = 6;
    localparam int  RESET_CYCLES  = 12;
    localparam int  RANDOM_VALUES = 148;
    localparam int  CALM_FROM     = 120;
    localparam int  TAIL_CYCLES   = 60;
    localparam int  STALL_LIMIT   = 2000;
    localparam int  DIRECTED_N    = 22;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic                o_ready;
    logic [VALUE_W-1:0]  i_value       = '0;
    logic [SIZE_W-1:0]   i_buffer_size = '0;
    logic                o_valid;
    logic                i_ready       = 1'b0;
    logic [CHAR_W-1:0]   o_character;
    logic                o_last;

    int fail_count;
    int pending;
    int value_count;
    int silent_count;
    int char_count;
    bit calm = 1'b0;

    // edge cases: zero, all ones, digit-count boundaries, sizes 0, 1, 2, 11, 255
    logic [VALUE_W-1:0] dir_value [DIRECTED_N] = '{
        32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd9, 32'd10, 32'd10, 32'd99,
        32'd100, 32'd999_999_999, 32'd1_000_000_000, 32'd1_000_000_000,
        32'd123_456_789, 32'd4_000_000_000, 32'd7, 32'd12_345
    };
    logic [SIZE_W-1:0] dir_size [DIRECTED_N] = '{
        8'd0, 8'd1, 8'd2, 8'd255, 8'd1, 8'd2, 8'd10,
        8'd11, 8'd255, 8'd11, 8'd3, 8'd2, 8'd3, 8'd11,
        8'd4, 8'd11, 8'd11, 8'd6,
        8'd12, 8'd128, 8'd170, 8'd85
    };

    always #(CLK_HALF) i_clk = ~i_clk;

    uint32_to_decimal_ascii_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .i_buffer_size (i_buffer_size),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_character   (o_character),
        .o_last        (o_last)
    );

    uint32_to_decimal_ascii_core_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_value        (i_value),
        .i_buffer_size  (i_buffer_size),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_character    (o_character),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_value_count  (value_count),
        .o_silent_count (silent_count),
        .o_char_count   (char_count)
    );

    // mostly values spread over every digit count, with boundaries and raw words
    function automatic logic [VALUE_W-1:0] pick_value();
        int mode;
        int n;
        longint lo;
        longint hi;
        mode = $urandom_range(0, 15);
        if (mode == 0)
            return '0;
        if (mode == 1)
            return $urandom;
        n  = $urandom_range(1, NUM_DIGITS);
        lo = 1;
        repeat (n - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (hi > 64'hFFFF_FFFF)
            hi = 64'hFFFF_FFFF;
        if (n == 1)
            lo = 0;
        if (mode == 2)
            return VALUE_W'(lo);
        if (mode == 3)
            return VALUE_W'(hi);
        return $urandom_range(VALUE_W'(hi), VALUE_W'(lo));
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return SIZE_W'($urandom_range(0, 1));
        if (r == 1)
            return SIZE_W'($urandom_range(0, 255));
        return SIZE_W'($urandom_range(2, 12));
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] value,
                              input logic [SIZE_W-1:0] size);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_value       <= value;
        i_buffer_size <= size;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // output back-pressure: stall bursts, steady stretches, single beats
    initial begin
        forever begin
            @(posedge i_clk);
            case ($urandom_range(0, 3))
                0: begin
                    if (!calm) begin
                        i_ready <= 1'b0;
                        repeat ($urandom_range(1, 10)) @(posedge i_clk);
                    end
                    i_ready <= 1'b1;
                end
                1: begin
                    i_ready <= 1'b1;
                    repeat ($urandom_range(20, 60)) @(posedge i_clk);
                end
                default: i_ready <= 1'b1;
            endcase
        end
    end

    // ends the run when no transaction has moved for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        do begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end while (idle_cycles < STALL_LIMIT);
        $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("uint32_to_decimal_ascii_core_tb NOT OK");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < DIRECTED_N; i++)
            send_value(dir_value[i], dir_size[i]);
        for (int i = 0; i < RANDOM_VALUES; i++) begin
            if (i == CALM_FROM)
                calm = 1'b1;
            send_value(pick_value(), pick_size());
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("converted %0d values (%0d below the minimum size) into %0d characters",
                 value_count, silent_count, char_count);
        $display("random back-pressure and input gaps, quiet in the final stretch");
        if (fail_count == 0)
            $display("uint32_to_decimal_ascii_core_tb OK");
        else
            $display("uint32_to_decimal_ascii_core_tb NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
design/u2da_pkg.sv
design/u2da_cell.sv
design/uint32_to_decimal_ascii_core.sv
sim/uint32_to_decimal_ascii_core_checker.sv
sim/uint32_to_decimal_ascii_core_tb.sv
